// ----- sv/interval_reservation_table_top_assert.svh -----
// Assertion macros for the checker file of the reservation table.
`ifndef INTERVAL_RESERVATION_TABLE_TOP_ASSERT_SVH
`define INTERVAL_RESERVATION_TABLE_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define IRT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("reservation table check failed");

// A condition that must be followed by another one in the next cycle.
`define IRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("reservation table sequence check failed");

`endif

// ----- sv/irt_pkg.sv -----
package irt_pkg;

  // Table geometry.
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Operation codes.
  localparam logic [2:0] FN_REQUEST   = 3'd0;
  localparam logic [2:0] FN_RELEASE   = 3'd1;
  localparam logic [2:0] FN_PURGE_REL = 3'd2;
  localparam logic [2:0] FN_PURGE_EXP = 3'd3;
  localparam logic [2:0] FN_QUERY     = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] train_id;
    logic [3:0]  zone_type;
    logic [15:0] zone_node;
    logic [15:0] zone_track;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       conflict;
    logic [5:0] entries_used;
  } res_t;

  // One stored reservation.
  typedef struct packed {
    logic [15:0] owner;
    logic [3:0]  zone_type;
    logic [15:0] zone_node;
    logic [15:0] zone_track;
    logic [31:0] start_ms;
    logic [31:0] end_ms;
    logic        released;
  } entry_t;

  typedef enum logic [1:0] {
    WR_NEW,
    WR_COPY,
    WR_RELEASE
  } wsel_e;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  // Table port command from the sequencer.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    wsel_e            wsel;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_cmd_t;

  // Compare results for the entry read last cycle.
  typedef struct packed {
    logic conflict;
    logic rel_hit;
    logic drop;
  } hit_t;

endpackage

// ----- sv/irt_table.sv -----
module irt_table (
  input  logic            clk_i,
  input  irt_pkg::req_t    req_i,
  input  irt_pkg::mem_cmd_t cmd_i,
  output irt_pkg::hit_t    hit_o
);
  import irt_pkg::*;

  entry_t mem_q [CAPACITY];
  entry_t rd_q;
  entry_t wdata;
  logic   zone_eq;

  // Write data: a fresh entry, a moved entry, or the read entry marked released.
  always_comb begin
    wdata = rd_q;
    unique case (cmd_i.wsel)
      WR_NEW: begin
        wdata.owner      = req_i.train_id;
        wdata.zone_type  = req_i.zone_type;
        wdata.zone_node  = req_i.zone_node;
        wdata.zone_track = req_i.zone_track;
        wdata.start_ms   = req_i.start_time;
        wdata.end_ms     = req_i.end_time;
        wdata.released   = 1'b0;
      end
      WR_COPY:    wdata = rd_q;
      WR_RELEASE: wdata.released = 1'b1;
      default:    wdata = rd_q;
    endcase
  end

  // Single write port, single registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[cmd_i.waddr] <= wdata;
    end
    if (cmd_i.re) begin
      rd_q <= mem_q[cmd_i.raddr];
    end
  end

  // Shared compare unit applied to one entry per cycle.
  always_comb begin
    zone_eq = (rd_q.zone_type == req_i.zone_type) &&
              (rd_q.zone_node == req_i.zone_node) &&
              (rd_q.zone_track == req_i.zone_track);
    hit_o.conflict = !rd_q.released && (rd_q.owner != req_i.train_id) && zone_eq &&
                     (req_i.start_time < rd_q.end_ms) && (rd_q.start_ms < req_i.end_time);
    hit_o.rel_hit  = !rd_q.released && (rd_q.owner == req_i.train_id) && zone_eq;
    hit_o.drop     = (req_i.func == FN_PURGE_REL) ? rd_q.released
                                                  : (rd_q.end_ms <= req_i.now_time);
  end

endmodule

// ----- sv/interval_reservation_table_top.sv -----
// Interval reservation table with up to 32 entries kept in insertion order.
// A request is taken when start is high and busy is low. The result appears on
// res_o for exactly one cycle with result_valid_o high and cannot be held off,
// so the receiver must take it in that cycle. An invalid request or an unknown
// function answers in the next cycle without a scan and keeps busy low. Every
// other function walks the table through one read port and one compare unit,
// one entry per cycle, and busy stays high for the whole walk, which covers
// every entry held when the request is taken unless a conflict or a release
// match ends it early; the result follows in the cycle where busy falls.
// Purges compact the table in the same walk and always cover every entry.
module interval_reservation_table_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  irt_pkg::req_t req_i,
  output logic          busy,
  output logic          result_valid_o,
  output irt_pkg::res_t res_o
);
  import irt_pkg::*;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  res_t             res_q, res_d;
  logic             res_v_q, res_v_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] kept_q, kept_d;
  logic [CNT_W-1:0] ev_idx_q, ev_idx_d;
  logic             ev_v_q, ev_v_d;
  mem_cmd_t         cmd;
  hit_t             hit;

  irt_table u_table (
    .clk_i (clk_i),
    .req_i (req_q),
    .cmd_i (cmd),
    .hit_o (hit)
  );

  // Sequencer: accept, walk the table or answer at once, finish with one result.
  always_comb begin
    logic found;
    logic last;
    logic finish;
    logic do_read;

    state_d  = state_q;
    req_d    = req_q;
    res_d    = res_q;
    res_v_d  = 1'b0;
    count_d  = count_q;
    idx_d    = idx_q;
    kept_d   = kept_q;
    ev_v_d   = 1'b0;
    ev_idx_d = ev_idx_q;
    cmd      = '0;
    found    = 1'b0;
    last     = 1'b0;
    finish   = 1'b0;
    do_read  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d  = req_i;
          idx_d  = '0;
          kept_d = '0;
          case (req_i.func) inside
            FN_REQUEST: begin
              if ((req_i.train_id == '0) || (req_i.end_time <= req_i.start_time)) begin
                res_v_d = 1'b1;
                res_d   = '{status: ST_INVALID, conflict: 1'b0, entries_used: count_q};
              end else begin
                state_d = S_SCAN;
              end
            end
            FN_RELEASE, FN_PURGE_REL, FN_PURGE_EXP, FN_QUERY: begin
              state_d = S_SCAN;
            end
            default: begin
              res_v_d = 1'b1;
              res_d   = '{status: ST_INVALID, conflict: 1'b0, entries_used: count_q};
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous entry is evaluated.
        do_read   = (idx_q < count_q);
        cmd.re    = do_read;
        cmd.raddr = idx_q[IDX_W-1:0];
        if (do_read) begin
          idx_d = idx_q + 1'b1;
        end
        ev_v_d   = do_read;
        ev_idx_d = idx_q;
        last     = ev_v_q && (ev_idx_q == count_q - 1'b1);

        // Evaluate the entry read in the previous cycle.
        if (ev_v_q) begin
          case (req_q.func) inside
            FN_REQUEST, FN_QUERY: begin
              found = hit.conflict;
            end
            FN_RELEASE: begin
              if (hit.rel_hit) begin
                found     = 1'b1;
                cmd.we    = 1'b1;
                cmd.waddr = ev_idx_q[IDX_W-1:0];
                cmd.wsel  = WR_RELEASE;
              end
            end
            FN_PURGE_REL, FN_PURGE_EXP: begin
              if (!hit.drop) begin
                if (kept_q != ev_idx_q) begin
                  cmd.we    = 1'b1;
                  cmd.waddr = kept_q[IDX_W-1:0];
                  cmd.wsel  = WR_COPY;
                end
                kept_d = kept_q + 1'b1;
              end
            end
            default: ;
          endcase
        end

        finish = (count_q == '0) || last || found;

        // Close the operation and form the result.
        if (finish) begin
          state_d = S_IDLE;
          ev_v_d  = 1'b0;
          res_v_d = 1'b1;
          res_d   = '{status: ST_OK, conflict: 1'b0, entries_used: count_q};
          case (req_q.func) inside
            FN_REQUEST: begin
              if (found) begin
                res_d.status   = ST_REFUSED;
                res_d.conflict = 1'b1;
              end else if (count_q >= CNT_W'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                cmd.we             = 1'b1;
                cmd.waddr          = count_q[IDX_W-1:0];
                cmd.wsel           = WR_NEW;
                count_d            = count_q + 1'b1;
                res_d.entries_used = count_q + 1'b1;
              end
            end
            FN_QUERY: begin
              res_d.conflict = found;
            end
            FN_RELEASE: begin
              if (!found) begin
                res_d.status = ST_REFUSED;
              end
            end
            FN_PURGE_REL, FN_PURGE_EXP: begin
              count_d            = kept_d;
              res_d.entries_used = kept_d;
            end
            default: begin
              res_d.status = ST_INVALID;
            end
          endcase
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      res_v_q <= 1'b0;
      ev_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      res_v_q <= res_v_d;
      ev_v_q  <= ev_v_d;
    end
  end

  // Payload and walk indexes.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    res_q    <= res_d;
    idx_q    <= idx_d;
    kept_q   <= kept_d;
    ev_idx_q <= ev_idx_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_v_q;
  assign res_o          = res_q;

endmodule

// ----- sv/irt_check.sv -----
`include "interval_reservation_table_top_assert.svh"

module irt_check (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input irt_pkg::req_t req_i,
  input logic          busy,
  input logic          result_valid_o,
  input irt_pkg::res_t res_o
);
  import irt_pkg::*;

  logic shown_full;
  logic full_ok;
  logic shown_conflict;
  logic conflict_ok;

  // Shorthands for the shown result.
  assign shown_full     = result_valid_o && (res_o.status == ST_FULL);
  assign full_ok        = (res_o.entries_used == 6'(CAPACITY)) && !res_o.conflict;
  assign shown_conflict = result_valid_o && res_o.conflict;
  assign conflict_ok    = (res_o.status == ST_OK) || (res_o.status == ST_REFUSED);

  // An accepted request either answers at once or starts a table walk.
  `IRT_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start && !busy, result_valid_o || busy)

  // A walk always ends with its result in the cycle where busy drops.
  `IRT_ASSERT(a_walk_result, clk_i, rst_ni, !$fell(busy) || result_valid_o)

  // A full-table refusal only happens with every entry in use.
  `IRT_ASSERT(a_full_count, clk_i, rst_ni, !shown_full || full_ok)

  // A reported conflict comes with a grant-style query answer or a refusal.
  `IRT_ASSERT(a_conflict_status, clk_i, rst_ni, !shown_conflict || conflict_ok)

  // The table never reports more entries than its capacity.
  `IRT_ASSERT(a_used_range, clk_i, rst_ni, !result_valid_o || res_o.entries_used <= 6'(CAPACITY))

endmodule

bind interval_reservation_table_top irt_check u_irt_check (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .req_i          (req_i),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .res_o          (res_o)
);
